### rtl/core/asf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_pkg
// Shared types and constants of the altimeter sample framer.
// ----------------------------------------------------------------------------
package asf_pkg;

  localparam int unsigned FrameBytes  = 23;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 8;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = 1;
  localparam int unsigned QueueCntW   = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSyncSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMessageId  = 2'd2;

  // Byte positions inside the frame.
  localparam logic [IdxW-1:0] PosSyncFirst  = 5'd0;
  localparam logic [IdxW-1:0] PosSyncSecond = 5'd1;
  localparam logic [IdxW-1:0] PosMessageId  = 5'd2;
  localparam logic [IdxW-1:0] PosLenLo      = 5'd3;
  localparam logic [IdxW-1:0] PosLenHi      = 5'd4;
  localparam logic [IdxW-1:0] PosPayload    = 5'd5;
  localparam logic [IdxW-1:0] PosCkA        = 5'd21;
  localparam logic [IdxW-1:0] PosCkB        = 5'd22;

  localparam logic [15:0] PayloadLen = 16'd16;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] message_id;
  } cfg_t;

  typedef struct packed {
    logic [63:0] stamp_us;
    logic [31:0] status_word;
    logic [31:0] range_value;
  } sample_t;

endpackage

### rtl/core/asf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_front
// Input side: accepts samples and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module asf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  asf_pkg::sample_t  sample_i,
  output logic              valid_o,
  output asf_pkg::sample_t  sample_o,
  input  logic              take_i
);

  asf_pkg::sample_t                   entry_q [asf_pkg::QueueDepth];
  logic [asf_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [asf_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [asf_pkg::QueueCntW-1:0]      cnt_q, cnt_d;
  logic                               push_ok;
  logic                               take_ok;

  assign full_o   = (cnt_q == asf_pkg::QueueCntW'(asf_pkg::QueueDepth));
  assign valid_o  = (cnt_q != '0);
  assign sample_o = entry_q[rd_ptr_q];
  assign push_ok  = push_i && !full_o;
  assign take_ok  = take_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (take_ok) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_ok && !take_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_ok && take_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= sample_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3))
    else $error("sample queue count out of range");

endmodule

### rtl/core/asf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asf_back
// Output side: serializes one sample into a frame, one byte per transfer,
// and forms the Fletcher checksum pair on the way.
// ----------------------------------------------------------------------------
module asf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  asf_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  asf_pkg::sample_t  sample_i,
  output logic              take_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        frame_byte_o,
  output logic              last_byte_o
);

  logic [asf_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]               ck_a_q, ck_a_d;
  logic [7:0]               ck_b_q, ck_b_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_byte_q;
  logic                     out_last_q;
  logic                     pop_ok;
  logic                     adv;
  logic [7:0]               cur_byte;
  logic [asf_pkg::IdxW-1:0] poff;
  logic [127:0]             payload;
  logic                     in_sum;

  assign pop_ok  = pop_i && out_valid_q;
  assign adv     = valid_i && (!out_valid_q || pop_ok);
  assign take_o  = adv && (idx_q == asf_pkg::PosCkB);
  assign payload = sample_i;
  assign poff    = idx_q - asf_pkg::PosPayload;
  assign in_sum  = (idx_q >= asf_pkg::PosMessageId) && (idx_q < asf_pkg::PosCkA);

  always_comb begin
    case (idx_q)
      asf_pkg::PosSyncFirst:  cur_byte = cfg_i.sync_first;
      asf_pkg::PosSyncSecond: cur_byte = cfg_i.sync_second;
      asf_pkg::PosMessageId:  cur_byte = cfg_i.message_id;
      asf_pkg::PosLenLo:      cur_byte = asf_pkg::PayloadLen[7:0];
      asf_pkg::PosLenHi:      cur_byte = asf_pkg::PayloadLen[15:8];
      asf_pkg::PosCkA:        cur_byte = ck_a_q;
      asf_pkg::PosCkB:        cur_byte = ck_b_q;
      default:                cur_byte = payload[{poff[3:0], 3'b000} +: 8];
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    ck_a_d      = ck_a_q;
    ck_b_d      = ck_b_q;
    out_valid_d = out_valid_q;
    if (pop_ok) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      if (idx_q == asf_pkg::PosCkB) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
      if (idx_q == asf_pkg::PosSyncFirst) begin
        ck_a_d = '0;
        ck_b_d = '0;
      end else if (in_sum) begin
        ck_a_d = ck_a_q + cur_byte;
        ck_b_d = ck_b_q + ck_a_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ck_a_q <= ck_a_d;
    ck_b_q <= ck_b_d;
    if (adv) begin
      out_byte_q <= cur_byte;
      out_last_q <= (idx_q == asf_pkg::PosCkB);
    end
  end

  assign empty_o      = !out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q <= asf_pkg::PosCkB))
    else $error("frame byte index out of range");

  a_frame_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && idx_q == asf_pkg::PosCkB) |=> (idx_q == '0 && out_last_q && out_valid_q))
    else $error("frame did not close on the checksum byte");

  a_frame_mid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && idx_q != asf_pkg::PosCkB) |=>
      (!out_last_q && idx_q == $past(idx_q) + 1'b1))
    else $error("byte index or end flag wrong inside a frame");

endmodule

### rtl/core/altimeter_sample_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altimeter_sample_framer
// Frames altimeter samples into 23-byte packets with a Fletcher checksum.
// ----------------------------------------------------------------------------
// Each accepted sample becomes one 23-byte frame delivered one byte per
// transfer: two sync bytes, the message id, the length 16 in little-endian
// order, range, status and timestamp in little-endian order, and the
// checksum pair, with last_byte_o set on the final byte. The byte serializer
// emits one byte per cycle while the receiver pops every cycle; a two-entry
// sample queue lets new samples be accepted while a frame is still going
// out. When the block is idle, the first byte of a frame passes through the
// sample queue and then the output byte register. Configuration writes take
// effect at once and are meant to happen while no frame is pending.
module altimeter_sample_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [asf_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            range_value_i,
  input  logic [31:0]                   status_word_i,
  input  logic [63:0]                   stamp_us_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    frame_byte_o,
  output logic                          last_byte_o
);

  asf_pkg::cfg_t    cfg_q;
  asf_pkg::sample_t in_sample;
  asf_pkg::sample_t q_sample;
  logic             q_valid;
  logic             q_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= 8'd181;
      cfg_q.sync_second <= 8'd98;
      cfg_q.message_id  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asf_pkg::RegSyncFirst:  cfg_q.sync_first  <= cfg_data_i;
        asf_pkg::RegSyncSecond: cfg_q.sync_second <= cfg_data_i;
        asf_pkg::RegMessageId:  cfg_q.message_id  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_sample.stamp_us    = stamp_us_i;
  assign in_sample.status_word = status_word_i;
  assign in_sample.range_value = range_value_i;

  asf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .sample_i (in_sample),
    .valid_o  (q_valid),
    .sample_o (q_sample),
    .take_i   (q_take)
  );

  asf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .valid_i      (q_valid),
    .sample_i     (q_sample),
    .take_o       (q_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

### tb/sv/tb_altimeter_sample_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_altimeter_sample_framer
// Self-checking testbench for the altimeter sample framer.
// ----------------------------------------------------------------------------
// Samples are offered through the push/full side and every frame byte is
// taken through the empty/pop side. A frame builder inside the testbench
// keeps its own copy of the sync and id registers, lays out each accepted
// sample as a 23-byte frame with its Fletcher checksum pair, and queues the
// bytes. Each transfer out of the block is checked against the oldest
// queued byte. A short table of directed samples runs first under the reset
// register values, some rows with the checksum pair typed in. Then several
// phases of random samples follow, each under new register values, with
// random idle bursts on both sides, one long hold-off of the receiver that
// fills the block, and a last phase with no idling.
// ----------------------------------------------------------------------------
module tb_altimeter_sample_framer;
  import asf_pkg::*;

  localparam int unsigned NumDirected   = 12;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 73;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned CycleLimit    = 1000000;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct {
    logic [31:0] range_value;
    logic [31:0] status_word;
    logic [63:0] stamp_us;
    bit          ck_typed;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
  } sample_row_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  logic signed [31:0]  range_value_i;
  logic [31:0]         status_word_i;
  logic [63:0]         stamp_us_i;
  logic                empty;
  logic                pop;
  logic [7:0]          frame_byte_o;
  logic                last_byte_o;

  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  logic [7:0]  message_id_q;
  frame_byte_t frame_bytes_due [$];
  frame_byte_t due_byte;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet_run;
  bit          rx_hold_req;

  sample_row_t directed_rows [NumDirected] = '{
    '{32'h0000_0000, 32'h0000_0000, 64'h0, 1'b1, 8'h11, 8'h33},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h01, 8'hAB},
    '{32'h8000_0000, 32'h0000_0000, 64'h0, 1'b1, 8'h91, 8'hB3},
    '{32'h7FFF_FFFF, 32'h0000_0000, 64'h0, 1'b1, 8'h8D, 8'h79},
    '{32'h0000_0000, 32'hFFFF_FFFF, 64'h0, 1'b0, 8'h00, 8'h00},
    '{32'h0000_0000, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 8'h00},
    '{32'h0000_0000, 32'h0000_0000, 64'h8000_0000_0000_0000, 1'b0, 8'h00, 8'h00},
    '{32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 8'h00, 8'h00},
    '{32'h5555_5555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 8'h00, 8'h00},
    '{32'h0403_0201, 32'h0807_0605, 64'h100F_0E0D_0C0B_0A09, 1'b0, 8'h00, 8'h00},
    '{32'hFFFF_FFFE, 32'h0000_0001, 64'h0000_0000_0000_0001, 1'b0, 8'h00, 8'h00},
    '{32'h0000_0001, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 8'h00}
  };

  altimeter_sample_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .range_value_i (range_value_i),
    .status_word_i (status_word_i),
    .stamp_us_i    (stamp_us_i),
    .empty         (empty),
    .pop           (pop),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb_altimeter_sample_framer failed");
    $finish;
  end

  function automatic void queue_frame(input logic [31:0] rng, input logic [31:0] st,
                                      input logic [63:0] ts, input bit ck_typed,
                                      input logic [7:0] typed_a, input logic [7:0] typed_b);
    logic [7:0] fr [FrameBytes];
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    sum_a = 8'h00;
    sum_b = 8'h00;
    fr[PosSyncFirst]  = sync_first_q;
    fr[PosSyncSecond] = sync_second_q;
    fr[PosMessageId]  = message_id_q;
    fr[PosLenLo]      = PayloadLen[7:0];
    fr[PosLenHi]      = PayloadLen[15:8];
    for (int k = 0; k < 4; k++) begin
      fr[PosPayload + k]     = rng[8*k +: 8];
      fr[PosPayload + 4 + k] = st[8*k +: 8];
    end
    for (int k = 0; k < 8; k++) begin
      fr[PosPayload + 8 + k] = ts[8*k +: 8];
    end
    for (int k = PosMessageId; k < PosCkA; k++) begin
      sum_a = sum_a + fr[k];
      sum_b = sum_b + sum_a;
    end
    fr[PosCkA] = ck_typed ? typed_a : sum_a;
    fr[PosCkB] = ck_typed ? typed_b : sum_b;
    for (int k = 0; k < FrameBytes; k++) begin
      frame_bytes_due.push_back('{fr[k], (k == PosCkB)});
    end
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: pick_word = 32'h0000_0000;
      1: pick_word = 32'hFFFF_FFFF;
      2: pick_word = 32'h8000_0000;
      3: pick_word = 32'h7FFF_FFFF;
      4: pick_word = $urandom_range(0, 255);
      default: pick_word = $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] rng, input logic [31:0] st,
                             input logic [63:0] ts, input bit ck_typed,
                             input logic [7:0] typed_a, input logic [7:0] typed_b);
    if (!quiet_run && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    push          <= 1'b1;
    range_value_i <= rng;
    status_word_i <= st;
    stamp_us_i    <= ts;
    do @(posedge clk_i); while (full);
    queue_frame(rng, st, ts, ck_typed, typed_a, typed_b);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] id);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegSyncFirst;
    cfg_data_i <= s1;
    @(posedge clk_i);
    sync_first_q = s1;
    cfg_idx_i  <= RegSyncSecond;
    cfg_data_i <= s2;
    @(posedge clk_i);
    sync_second_q = s2;
    cfg_idx_i  <= RegMessageId;
    cfg_data_i <= id;
    @(posedge clk_i);
    message_id_q = id;
    // A write to the unused index must leave all registers alone.
    cfg_idx_i  <= RegUnused;
    cfg_data_i <= CfgDataW'($urandom_range(0, 255));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got byte %h last %b",
                 $time, frame_byte_o, last_byte_o);
        mismatches++;
      end else begin
        due_byte = frame_bytes_due.pop_front();
        if (frame_byte_o !== due_byte.value) begin
          $display("%0t: frame_byte expected %h, got %h", $time, due_byte.value,
                   frame_byte_o);
          mismatches++;
        end
        if (last_byte_o !== due_byte.last) begin
          $display("%0t: last_byte expected %b, got %b", $time, due_byte.last,
                   last_byte_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    logic        next_pop;
    stall_left = 0;
    hold_left  = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      next_pop = 1'b1;
      if (rx_hold_req) begin
        if (hold_left == 0) hold_left = HoldCycles;
        hold_left--;
        next_pop = 1'b0;
        if (hold_left == 0) rx_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        next_pop = 1'b0;
      end
      pop <= next_pop;
    end
  end

  initial begin
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] id;
    mismatches     = 0;
    quiet_run      = 1'b0;
    rx_hold_req    = 1'b0;
    sync_first_q   = 8'hB5;
    sync_second_q  = 8'h62;
    message_id_q   = 8'h01;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= RegSyncFirst;
    cfg_data_i     <= '0;
    push           <= 1'b0;
    range_value_i  <= '0;
    status_word_i  <= '0;
    stamp_us_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_sample(directed_rows[r].range_value, directed_rows[r].status_word,
                  directed_rows[r].stamp_us, directed_rows[r].ck_typed,
                  directed_rows[r].ck_a, directed_rows[r].ck_b);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      quiet_run = (ph == NumPhases - 1);
      drain();
      case (ph)
        0: begin s1 = 8'h00; s2 = 8'h00; id = 8'h00; end
        1: begin s1 = 8'hFF; s2 = 8'hFF; id = 8'hFF; end
        4: begin s1 = 8'hB5; s2 = 8'h62; id = 8'h01; end
        default: begin
          s1 = 8'($urandom_range(0, 255));
          s2 = 8'($urandom_range(0, 255));
          id = 8'($urandom_range(0, 255));
        end
      endcase
      write_config(s1, s2, id);
      if (ph == PressurePhase) rx_hold_req = 1'b1;
      repeat (ItemsPerPhase) begin
        send_sample(pick_word(), pick_word(), {pick_word(), pick_word()}, 1'b0,
                    8'h00, 8'h00);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("tb_altimeter_sample_framer passed");
    end else begin
      $display("tb_altimeter_sample_framer failed");
    end
    $finish;
  end

endmodule
